@@ sv/epoch_seconds_to_utc_date_unit_assert.svh @@
// assertion macros used by the checker file of the epoch date converter
// no dependencies; clocked on clk and disabled while arst_n is low
`ifndef EPOCH_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_UNIT_ASSERT_SVH

// same-cycle implication
`define ESUD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/esud_pkg.sv @@
// shared constants, types and the month offset table of the epoch date converter
// no dependencies
package esud_pkg;

	localparam int NUM_STAGES = 17;

	// seconds per day is 675 << 7, hour is 225 << 4, minute is 15 << 2
	localparam logic [9:0]  DAY_DIV   = 10'd675;
	localparam logic [15:0] DAY_RCP   = 16'd49710;  // floor(2^25 / 675)
	localparam logic [7:0]  HR_DIV    = 8'd225;
	localparam logic [5:0]  HR_RCP    = 6'd36;      // floor(2^13 / 225)
	localparam logic [3:0]  MIN_DIV   = 4'd15;
	localparam logic [6:0]  MIN_RCP   = 7'd68;      // floor(2^10 / 15)

	// era / day-of-era constants
	localparam logic [15:0] ERA5_DAY  = 16'd11017;  // 5*146097 - 719468
	localparam logic [17:0] DOE_OFS4  = 18'd135080; // 719468 - 4*146097
	localparam logic [17:0] DOE_CENT1 = 18'd36524;
	localparam logic [17:0] DOE_CENT2 = 18'd73048;
	localparam logic [17:0] DOE_CENT3 = 18'd109572;
	localparam logic [8:0]  YEAR_DAYS = 9'd365;
	localparam logic [7:0]  QUAD_RCP  = 8'd179;     // floor(2^16 / 365)
	localparam logic [9:0]  YOE_RCP   = 10'd718;    // floor(2^18 / 365)
	localparam logic [8:0]  YOE_C1    = 9'd100;
	localparam logic [8:0]  YOE_C2    = 9'd200;
	localparam logic [8:0]  YOE_C3    = 9'd300;
	localparam logic [11:0] YEAR_ERA4 = 12'd1600;
	localparam logic [11:0] YEAR_ERA5 = 12'd2000;

	// month index counted from march
	localparam logic [7:0]  MP_DIV    = 8'd153;
	localparam logic [3:0]  MP_RCP    = 4'd13;      // floor(2^11 / 153)
	localparam logic [3:0]  MP_JAN    = 4'd10;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// first day-of-year of each march-based month, (153*mp + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/epoch_seconds_to_utc_date_unit.sv @@
// epoch seconds to utc civil date and time, fully pipelined
// depends on esud_pkg
//
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------------
//  in      | in_valid in_ready epoch_seconds  | one request: 32-bit unix seconds
//  out     | out_valid out_ready year month   | one result per request
//          | day hour minute second           |
//
// one request per cycle sustained while out_ready is high, 17 register stages:
// an accepted request moves through s1 to s17 in turn, and s17 drives out_valid
// the depth comes from the chained reciprocal multiply / remainder fix-up steps
// (day split, day-of-era to year, year to march-based month)
// reset clears only the stage valid bits; payload registers are not reset
// each stage has its own load enable: a stalled output holds its result while
// earlier empty stages keep filling, so in_ready stays high until all are full
module epoch_seconds_to_utc_date_unit import esud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	// stage valid bits and per-stage load enables
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;
	logic [NUM_STAGES:1] vld_nxt;

	// a stage loads when it or any later stage is empty, or the output is taken
	for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_en
		assign en[g] = out_ready | ~(&vld_q[NUM_STAGES:g]);
	end

	assign vld_nxt  = {vld_q[NUM_STAGES-1:1], in_valid};
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_nxt[i];
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// pipeline registers
	// ---------------------------------------------------------------------
	// s1..s3: split into day number and second of day
	logic [24:0] t7_s1;
	logic [6:0]  tlo_s1, tlo_s2;
	logic [15:0] qd_s1, qd_s2;
	logic [10:0] rd_s2;
	logic [15:0] dn_s3;
	logic [16:0] sod_s3, sod_s4;

	// time-of-day track
	logic [4:0]  qh_s4, qh_s5;
	logic [8:0]  rh_s5;
	logic [3:0]  slo_s5;
	logic [4:0]  hh_s6, hh_s7, hh_s8;
	logic [11:0] mx_s6, mx_s7;
	logic [5:0]  qm_s7, qm_s8;
	logic [4:0]  rm_s8;
	logic [1:0]  xlo_s8;
	hms_t        hms_s9, hms_s10, hms_s11, hms_s12, hms_s13, hms_s14, hms_s15, hms_s16;
	hms_t        hms_s17;

	// date track
	logic        era5_s4, era5_s5, era5_s6, era5_s7, era5_s8, era5_s9, era5_s10, era5_s11;
	logic [17:0] doe_s4, doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [1:0]  ccent_s5, ccent_s6;
	logic [7:0]  qq_s5, qq_s6;
	logic [9:0]  rq_s6;
	logic [17:0] n_s7, n_s8;
	logic [8:0]  qy_s8, qy_s9;
	logic [9:0]  ry_s9;
	logic [8:0]  yoe_s10, yoe_s11;
	logic [17:0] m_s11;
	logic [8:0]  doy_s12, doy_s13, doy_s14, doy_s15, doy_s16;
	logic [11:0] yr_s12, yr_s13, yr_s14, yr_s15, yr_s16;
	logic [10:0] v_s13, v_s14;
	logic [3:0]  qmp_s14, qmp_s15;
	logic [8:0]  rmp_s15;
	logic [3:0]  mp_s16;
	logic [4:0]  day_s17;
	logic [3:0]  mon_s17;
	logic [11:0] yr_s17;

	// ---------------------------------------------------------------------
	// combinational work of each stage
	// ---------------------------------------------------------------------
	// s1: day estimate from seconds >> 7 times reciprocal of 675
	logic [40:0] day_prod;
	assign day_prod = 41'(epoch_seconds[31:7]) * 41'(DAY_RCP);

	// s2: raw remainder, below twice the divisor
	logic [24:0] rd_full;
	assign rd_full = t7_s1 - 25'(qd_s1) * 25'(DAY_DIV);

	// s3: one correction step
	logic        day_fix;
	logic [10:0] rd_adj;
	assign day_fix = (rd_s2 >= 11'(DAY_DIV));
	assign rd_adj  = day_fix ? (rd_s2 - 11'(DAY_DIV)) : rd_s2;

	// s4: era is 4 or 5 over the whole input range; hour estimate
	logic        era5_c;
	logic [17:0] doe_c;
	logic [17:0] hr_prod;
	assign era5_c  = (dn_s3 >= ERA5_DAY);
	assign doe_c   = era5_c ? (18'(dn_s3) - 18'(ERA5_DAY)) : (18'(dn_s3) + DOE_OFS4);
	assign hr_prod = 18'(sod_s3[16:4]) * 18'(HR_RCP);

	// s5: hour raw remainder; doe / 1460 estimate; centuries within the era
	logic [12:0] rh_full;
	logic [23:0] qq_prod;
	logic [1:0]  ccent_c;
	assign rh_full = sod_s4[16:4] - 13'(qh_s4) * 13'(HR_DIV);
	assign qq_prod = 24'(doe_s4[17:2]) * 24'(QUAD_RCP);
	// the last-day-of-era term cancels the fourth century step
	assign ccent_c = 2'(doe_s4 >= DOE_CENT1) + 2'(doe_s4 >= DOE_CENT2)
		+ 2'(doe_s4 >= DOE_CENT3);

	// s6: hour fix-up; quad-year raw remainder
	logic       hr_fix;
	logic [8:0] rh_adj;
	logic [15:0] rq_full;
	assign hr_fix  = (rh_s5 >= 9'(HR_DIV));
	assign rh_adj  = hr_fix ? (rh_s5 - 9'(HR_DIV)) : rh_s5;
	assign rq_full = doe_s5[17:2] - 16'(qq_s5) * 16'(YEAR_DAYS);

	// s7: leap-adjusted day count; minute estimate
	logic [17:0] n_c;
	logic [15:0] mn_prod;
	assign n_c = doe_s6 - 18'(qq_s6) - 18'(rq_s6 >= 10'(YEAR_DAYS)) + 18'(ccent_s6);
	assign mn_prod = 16'(mx_s6[11:2]) * 16'(MIN_RCP);

	// s8: year-of-era estimate; minute raw remainder
	logic [26:0] yr_prod;
	logic [9:0]  rm_full;
	assign yr_prod = 27'(n_s7) * 27'(YOE_RCP);
	assign rm_full = mx_s7[11:2] - 10'(qm_s7) * 10'(MIN_DIV);

	// s9: year raw remainder; minute and second fix-up
	logic [17:0] ry_full;
	logic        min_fix;
	logic [4:0]  rm_adj;
	assign ry_full = n_s8 - 18'(qy_s8) * 18'(YEAR_DAYS);
	assign min_fix = (rm_s8 >= 5'(MIN_DIV));
	assign rm_adj  = min_fix ? (rm_s8 - 5'(MIN_DIV)) : rm_s8;

	// s11: first day of the year within the era
	logic [1:0] c100;
	assign c100 = 2'(yoe_s10 >= YOE_C1) + 2'(yoe_s10 >= YOE_C2) + 2'(yoe_s10 >= YOE_C3);

	// s12: day of the march-based year
	logic [17:0] doy_full;
	assign doy_full = doe_s11 - m_s11;

	// s14: march-based month estimate
	logic [14:0] mp_prod;
	assign mp_prod = 15'(v_s13) * 15'(MP_RCP);

	// s15: month raw remainder
	logic [10:0] rmp_full;
	assign rmp_full = v_s14 - 11'(qmp_s14) * 11'(MP_DIV);

	// s17: calendar month and day
	logic       jan_feb;
	logic [8:0] dd_full;
	assign jan_feb = (mp_s16 >= MP_JAN);
	assign dd_full = doy_s16 - month_start(mp_s16) + 9'd1;

	// ---------------------------------------------------------------------
	// payload registers, no reset
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en[1]) begin
			t7_s1  <= epoch_seconds[31:7];
			tlo_s1 <= epoch_seconds[6:0];
			qd_s1  <= day_prod[40:25];
		end
		if (en[2]) begin
			rd_s2  <= rd_full[10:0];
			qd_s2  <= qd_s1;
			tlo_s2 <= tlo_s1;
		end
		if (en[3]) begin
			dn_s3  <= qd_s2 + 16'(day_fix);
			sod_s3 <= {rd_adj[9:0], tlo_s2};
		end
		if (en[4]) begin
			era5_s4 <= era5_c;
			doe_s4  <= doe_c;
			sod_s4  <= sod_s3;
			qh_s4   <= hr_prod[17:13];
		end
		if (en[5]) begin
			era5_s5  <= era5_s4;
			doe_s5   <= doe_s4;
			ccent_s5 <= ccent_c;
			qq_s5    <= qq_prod[23:16];
			rh_s5    <= rh_full[8:0];
			qh_s5    <= qh_s4;
			slo_s5   <= sod_s4[3:0];
		end
		if (en[6]) begin
			hh_s6    <= qh_s5 + 5'(hr_fix);
			mx_s6    <= {rh_adj[7:0], slo_s5};
			era5_s6  <= era5_s5;
			doe_s6   <= doe_s5;
			ccent_s6 <= ccent_s5;
			qq_s6    <= qq_s5;
			rq_s6    <= rq_full[9:0];
		end
		if (en[7]) begin
			n_s7    <= n_c;
			era5_s7 <= era5_s6;
			doe_s7  <= doe_s6;
			hh_s7   <= hh_s6;
			mx_s7   <= mx_s6;
			qm_s7   <= mn_prod[15:10];
		end
		if (en[8]) begin
			qy_s8   <= yr_prod[26:18];
			n_s8    <= n_s7;
			era5_s8 <= era5_s7;
			doe_s8  <= doe_s7;
			hh_s8   <= hh_s7;
			qm_s8   <= qm_s7;
			rm_s8   <= rm_full[4:0];
			xlo_s8  <= mx_s7[1:0];
		end
		if (en[9]) begin
			ry_s9          <= ry_full[9:0];
			qy_s9          <= qy_s8;
			era5_s9        <= era5_s8;
			doe_s9         <= doe_s8;
			hms_s9.hour    <= hh_s8;
			hms_s9.minute  <= qm_s8 + 6'(min_fix);
			hms_s9.second  <= {rm_adj[3:0], xlo_s8};
		end
		if (en[10]) begin
			yoe_s10  <= qy_s9 + 9'(ry_s9 >= 10'(YEAR_DAYS));
			era5_s10 <= era5_s9;
			doe_s10  <= doe_s9;
			hms_s10  <= hms_s9;
		end
		if (en[11]) begin
			m_s11    <= 18'(yoe_s10) * 18'(YEAR_DAYS) + 18'(yoe_s10[8:2]) - 18'(c100);
			yoe_s11  <= yoe_s10;
			era5_s11 <= era5_s10;
			doe_s11  <= doe_s10;
			hms_s11  <= hms_s10;
		end
		if (en[12]) begin
			doy_s12 <= doy_full[8:0];
			yr_s12  <= 12'(yoe_s11) + (era5_s11 ? YEAR_ERA5 : YEAR_ERA4);
			hms_s12 <= hms_s11;
		end
		if (en[13]) begin
			// 5 * doy + 2
			v_s13   <= {doy_s12, 2'b00} + 11'(doy_s12) + 11'd2;
			doy_s13 <= doy_s12;
			yr_s13  <= yr_s12;
			hms_s13 <= hms_s12;
		end
		if (en[14]) begin
			qmp_s14 <= mp_prod[14:11];
			v_s14   <= v_s13;
			doy_s14 <= doy_s13;
			yr_s14  <= yr_s13;
			hms_s14 <= hms_s13;
		end
		if (en[15]) begin
			rmp_s15 <= rmp_full[8:0];
			qmp_s15 <= qmp_s14;
			doy_s15 <= doy_s14;
			yr_s15  <= yr_s14;
			hms_s15 <= hms_s14;
		end
		if (en[16]) begin
			mp_s16  <= qmp_s15 + 4'(rmp_s15 >= 9'(MP_DIV));
			doy_s16 <= doy_s15;
			yr_s16  <= yr_s15;
			hms_s16 <= hms_s15;
		end
		if (en[17]) begin
			day_s17 <= dd_full[4:0];
			// january and february belong to the following year
			mon_s17 <= jan_feb ? (mp_s16 - 4'd9) : (mp_s16 + 4'd3);
			yr_s17  <= yr_s16 + 12'(jan_feb);
			hms_s17 <= hms_s16;
		end
	end

	// ---------------------------------------------------------------------
	// outputs
	// ---------------------------------------------------------------------
	assign out_valid = vld_q[NUM_STAGES];
	assign year      = yr_s17;
	assign month     = mon_s17;
	assign day       = day_s17;
	assign hour      = hms_s17.hour;
	assign minute    = hms_s17.minute;
	assign second    = hms_s17.second;

endmodule

@@ sv/esud_checker.sv @@
// port-level checks for the epoch date converter, bound to the top level
// depends on epoch_seconds_to_utc_date_unit_assert.svh
`include "epoch_seconds_to_utc_date_unit_assert.svh"

module esud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] epoch_seconds,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second
);

	// a stalled result holds
	`ESUD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(year) && $stable(month) && $stable(day) && $stable(hour) && $stable(minute) && $stable(second), "stalled result changed")

	// input only backs up when the pipe is full behind a stalled output
	`ESUD_ASSERT_NOW(a_ready_bp, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

	// date fields stay in the calendar range
	`ESUD_ASSERT_NOW(a_date_rng, out_valid, year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31, "date field out of range")

	// time fields stay in range
	`ESUD_ASSERT_NOW(a_time_rng, out_valid, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59, "time field out of range")

endmodule

bind epoch_seconds_to_utc_date_unit esud_checker u_esud_checker (.*);
